/* hdl/gplp_pkg.sv */
// Shared constants, codes and types of the grid point line projection block.
package gplp_pkg;

   // grade tables
   localparam int GRADE_DEPTH = 1024;
   localparam int GRADE_AW    = $clog2(GRADE_DEPTH);
   localparam int GRADE_W     = 32;
   localparam int INDEX_W     = 10;

   // configuration and arithmetic widths
   localparam int MODE_W      = 2;
   localparam int CSR_AW      = 3;
   localparam int COEF_W      = 48;
   localparam int COEF_HALF   = COEF_W / 2;
   localparam int PROJ_W      = 48;
   localparam int PROD_W      = GRADE_W + COEF_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int RND_SHIFT   = 24;
   localparam int SAT_LSB     = RND_SHIFT + PROJ_W - 1;

   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (RND_SHIFT - 1);
   localparam logic [PROJ_W-1:0] PROJ_MAX  = {1'b0, {(PROJ_W-1){1'b1}}};
   localparam logic [PROJ_W-1:0] PROJ_MIN  = {1'b1, {(PROJ_W-1){1'b0}}};

   // pipeline depth: table read, partial products, products, sums, select,
   // round, output register
   localparam int PIPE_STAGES = 7;

   // stream payload packing
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 48;
   localparam int RSP_USER_W  = 2;

   typedef enum logic [1:0] {
      REQ_WRITE_X = 2'd0,
      REQ_WRITE_Y = 2'd1,
      REQ_PROJECT = 2'd2
   } req_kind_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_HORIZ = 2'd0,
      MODE_VERT  = 2'd1,
      MODE_SLOPE = 2'd2
   } line_mode_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_LINE_MODE   = 3'd0,
      CSR_LINE_OFFSET = 3'd1,
      CSR_COS_COEF    = 3'd2,
      CSR_TAN_COEF    = 3'd3,
      CSR_SEC_COEF    = 3'd4,
      CSR_CSC_COEF    = 3'd5,
      CSR_SECCSC_COEF = 3'd6
   } csr_index_type;

   // result that bypasses the slope arithmetic (writes, flat lines, unused kinds)
   typedef struct packed {
      logic                     direct;
      logic                     inf;
      logic signed [PROJ_W-1:0] value;
   } direct_res_type;

endpackage

/* hdl/gplp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module gplp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* hdl/grid_point_line_projection.sv */
// Top level: grade tables and the pipelined point-onto-line projection.
//
// Usage
//   req_*  : one transfer per item. req_tuser is the kind: write x grade,
//            write y grade or project a point. Writes store grade_value at
//            entry_index of the x or y table; a project item reads x_index
//            and y_index from both tables and projects the point.
//   rsp_*  : exactly one transfer per accepted item, in order. Writes and
//            unused kinds answer with all zeros.
//   csr_*  : register write port, used only while the block is idle.
// Pipeline / throughput
//   Seven register stages, from the table read to the output register. One
//   item per cycle sustained while rsp_tready stays high: the tables are read
//   in the accept cycle, and each 32x48 multiply is formed as two 32x24 halves
//   in one stage and merged in the next, so every stage takes a new item each
//   cycle unless stalled. A write is visible to a read in the next cycle, so
//   no forwarding is needed.
// Reset
//   Synchronous, active high: clears the pipeline valid bits and the
//   configuration registers. Table contents are undefined until written.
// Stall
//   Each stage holds while the one after it is full and stalled, so bubbles
//   collapse; req_tready drops only once all seven stages are full.
module grid_point_line_projection
   import gplp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [9:0] entry_index, [41:10] grade_value, [51:42] x_index,
   // [61:52] y_index, [63:62] zero
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // [1:0] req_type
   input  logic [1:0]              req_tuser,
   // response stream
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [47:0] proj_value
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   // [0] at_infinity, [1] saturated
   output logic [RSP_USER_W-1:0]   rsp_tuser,
   // configuration
   input  logic                    csr_we,
   input  logic [CSR_AW-1:0]       csr_addr,
   input  logic [COEF_W-1:0]       csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [MODE_W-1:0]         mode_ff;
   logic signed [GRADE_W-1:0] offset_ff;
   logic signed [COEF_W-1:0]  tan_ff, sec_ff, csc_ff, seccsc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         offset_ff <= '0;
         tan_ff    <= '0;
         sec_ff    <= '0;
         csc_ff    <= '0;
         seccsc_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_LINE_MODE:   mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_LINE_OFFSET: offset_ff <= csr_wdata[GRADE_W-1:0];
            // cosine does not enter the projection; the write is dropped
            CSR_COS_COEF:    ;
            CSR_TAN_COEF:    tan_ff    <= csr_wdata;
            CSR_SEC_COEF:    sec_ff    <= csr_wdata;
            CSR_CSC_COEF:    csc_ff    <= csr_wdata;
            CSR_SECCSC_COEF: seccsc_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: per-stage valid, ready ripples back from the output
   // ---------------------------------------------------------------------
   logic [PIPE_STAGES-1:0] vld_ff, vld_in, stg_rdy, stg_load;
   logic                   accept;

   always_comb begin
      stg_rdy[PIPE_STAGES-1] = !vld_ff[PIPE_STAGES-1] || rsp_tready;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         stg_rdy[k] = !vld_ff[k] || stg_rdy[k+1];
      end
   end

   assign req_tready = stg_rdy[0];
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      stg_load[0] = accept;
      for (int k = 1; k < PIPE_STAGES; k++) begin
         stg_load[k] = vld_ff[k-1] && stg_rdy[k];
      end
      // a stage stays full only while stalled, unless a new item moves in
      vld_in = stg_load | (vld_ff & ~stg_rdy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------
   // Request unpacking and grade tables
   // ---------------------------------------------------------------------
   logic [INDEX_W-1:0]  ent_idx, x_idx, y_idx;
   logic [GRADE_W-1:0]  grade_val;
   logic [31:0]         ent_wide, x_wide, y_wide;
   logic                ent_ok, x_ok, y_ok;
   logic [GRADE_AW-1:0] ent_addr, x_addr, y_addr;
   logic                wr_x, wr_y;
   logic [GRADE_W-1:0]  x_rd, y_rd;

   assign ent_idx   = req_tdata[INDEX_W-1:0];
   assign grade_val = req_tdata[INDEX_W +: GRADE_W];
   assign x_idx     = req_tdata[INDEX_W+GRADE_W +: INDEX_W];
   assign y_idx     = req_tdata[2*INDEX_W+GRADE_W +: INDEX_W];

   assign ent_wide = 32'(ent_idx);
   assign x_wide   = 32'(x_idx);
   assign y_wide   = 32'(y_idx);
   assign ent_ok   = ent_wide < 32'(GRADE_DEPTH);
   assign x_ok     = x_wide < 32'(GRADE_DEPTH);
   assign y_ok     = y_wide < 32'(GRADE_DEPTH);
   assign ent_addr = ent_wide[GRADE_AW-1:0];
   assign x_addr   = x_wide[GRADE_AW-1:0];
   assign y_addr   = y_wide[GRADE_AW-1:0];

   assign wr_x = accept && (req_kind_type'(req_tuser) == REQ_WRITE_X) && ent_ok;
   assign wr_y = accept && (req_kind_type'(req_tuser) == REQ_WRITE_Y) && ent_ok;

   gplp_ram #(
      .WIDTH (GRADE_W),
      .DEPTH (GRADE_DEPTH)
   ) u_grade_x (
      .clock   (clock),
      .wr_en   (wr_x),
      .wr_addr (ent_addr),
      .wr_data (grade_val),
      .rd_en   (accept),
      .rd_addr (x_addr),
      .rd_data (x_rd)
   );

   gplp_ram #(
      .WIDTH (GRADE_W),
      .DEPTH (GRADE_DEPTH)
   ) u_grade_y (
      .clock   (clock),
      .wr_en   (wr_y),
      .wr_addr (ent_addr),
      .wr_data (grade_val),
      .rd_en   (accept),
      .rd_addr (y_addr),
      .rd_data (y_rd)
   );

   // stage 0: side info captured with the table read
   logic [1:0] kind0_ff;
   logic       x_ok0_ff, y_ok0_ff;

   always_ff @(posedge clock) begin
      if (stg_load[0]) begin
         kind0_ff <= req_tuser;
         x_ok0_ff <= x_ok;
         y_ok0_ff <= y_ok;
      end
   end

   logic signed [GRADE_W-1:0] gx0, gy0;
   assign gx0 = x_ok0_ff ? x_rd : '0;
   assign gy0 = y_ok0_ff ? y_rd : '0;

   // ---------------------------------------------------------------------
   // Stage 1: flat-line results and 32x24 partial products
   // ---------------------------------------------------------------------
   direct_res_type dir_in;
   logic signed [GRADE_W:0] gx_w, neg_off_w;

   assign gx_w      = (GRADE_W+1)'(gx0);
   assign neg_off_w = -(GRADE_W+1)'(offset_ff);

   always_comb begin
      dir_in = '{direct: 1'b1, inf: 1'b0, value: '0};
      case (req_kind_type'(kind0_ff))
         REQ_PROJECT: begin
            unique case (line_mode_type'(mode_ff))
               MODE_HORIZ: begin
                  if (gy0 <= offset_ff) begin
                     dir_in.value = PROJ_W'(gx0);
                  end else begin
                     dir_in.inf = 1'b1;
                  end
               end
               MODE_VERT: begin
                  if (gx_w <= neg_off_w) begin
                     dir_in.value = PROJ_W'(gy0);
                  end else begin
                     dir_in.inf = 1'b1;
                  end
               end
               default: begin
                  // general slope, also the spare mode code
                  dir_in.direct = 1'b0;
               end
            endcase
         end
         default: ;
      endcase
   end

   // coefficient halves: signed upper, unsigned lower
   logic signed [COEF_HALF-1:0] tan_hi, sec_hi, csc_hi, sc_hi;
   logic signed [COEF_HALF:0]   tan_lo, sec_lo, csc_lo, sc_lo;

   assign tan_hi = tan_ff[COEF_W-1:COEF_HALF];
   assign sec_hi = sec_ff[COEF_W-1:COEF_HALF];
   assign csc_hi = csc_ff[COEF_W-1:COEF_HALF];
   assign sc_hi  = seccsc_ff[COEF_W-1:COEF_HALF];
   assign tan_lo = $signed({1'b0, tan_ff[COEF_HALF-1:0]});
   assign sec_lo = $signed({1'b0, sec_ff[COEF_HALF-1:0]});
   assign csc_lo = $signed({1'b0, csc_ff[COEF_HALF-1:0]});
   assign sc_lo  = $signed({1'b0, seccsc_ff[COEF_HALF-1:0]});

   localparam int PH_W = GRADE_W + COEF_HALF;
   localparam int PL_W = GRADE_W + COEF_HALF + 1;

   logic signed [PH_W-1:0] xtan_h1_ff, osec_h1_ff, ycsc_h1_ff, xsec_h1_ff, osc_h1_ff;
   logic signed [PL_W-1:0] xtan_l1_ff, osec_l1_ff, ycsc_l1_ff, xsec_l1_ff, osc_l1_ff;
   logic signed [GRADE_W-1:0] gy1_ff;
   direct_res_type dir1_ff;

   always_ff @(posedge clock) begin
      if (stg_load[1]) begin
         xtan_h1_ff <= PH_W'(gx0) * PH_W'(tan_hi);
         xtan_l1_ff <= PL_W'(gx0) * PL_W'(tan_lo);
         osec_h1_ff <= PH_W'(offset_ff) * PH_W'(sec_hi);
         osec_l1_ff <= PL_W'(offset_ff) * PL_W'(sec_lo);
         ycsc_h1_ff <= PH_W'(gy0) * PH_W'(csc_hi);
         ycsc_l1_ff <= PL_W'(gy0) * PL_W'(csc_lo);
         xsec_h1_ff <= PH_W'(gx0) * PH_W'(sec_hi);
         xsec_l1_ff <= PL_W'(gx0) * PL_W'(sec_lo);
         osc_h1_ff  <= PH_W'(offset_ff) * PH_W'(sc_hi);
         osc_l1_ff  <= PL_W'(offset_ff) * PL_W'(sc_lo);
         gy1_ff     <= gy0;
         dir1_ff    <= dir_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: merge halves into full 80-bit products (40 fraction bits)
   // ---------------------------------------------------------------------
   logic signed [PROD_W-1:0] xtan2_ff, osec2_ff, ycsc2_ff, xsec2_ff, osc2_ff;
   logic signed [GRADE_W-1:0] gy2_ff;
   direct_res_type dir2_ff;

   always_ff @(posedge clock) begin
      if (stg_load[2]) begin
         xtan2_ff <= $signed({xtan_h1_ff, COEF_HALF'(0)}) + PROD_W'(xtan_l1_ff);
         osec2_ff <= $signed({osec_h1_ff, COEF_HALF'(0)}) + PROD_W'(osec_l1_ff);
         ycsc2_ff <= $signed({ycsc_h1_ff, COEF_HALF'(0)}) + PROD_W'(ycsc_l1_ff);
         xsec2_ff <= $signed({xsec_h1_ff, COEF_HALF'(0)}) + PROD_W'(xsec_l1_ff);
         osc2_ff  <= $signed({osc_h1_ff, COEF_HALF'(0)}) + PROD_W'(osc_l1_ff);
         gy2_ff   <= gy1_ff;
         dir2_ff  <= dir1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: line height at x, and both candidate results
   // ---------------------------------------------------------------------
   logic off_neg;
   assign off_neg = offset_ff[GRADE_W-1];

   logic signed [SUM_W-1:0] yl3_ff, yw3_ff, right3_ff, up3_ff;
   direct_res_type dir3_ff;

   always_ff @(posedge clock) begin
      if (stg_load[3]) begin
         yl3_ff    <= SUM_W'(xtan2_ff) + SUM_W'(osec2_ff);
         // y moved to 40 fraction bits
         yw3_ff    <= SUM_W'($signed({gy2_ff, RND_SHIFT'(0)}));
         right3_ff <= off_neg ? SUM_W'(ycsc2_ff) : SUM_W'(ycsc2_ff) - SUM_W'(osc2_ff);
         up3_ff    <= off_neg ? SUM_W'(xsec2_ff) + SUM_W'(osc2_ff) : SUM_W'(xsec2_ff);
         dir3_ff   <= dir2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: point on or above the line goes right, else up
   // ---------------------------------------------------------------------
   logic signed [SUM_W-1:0] r4_ff;
   direct_res_type dir4_ff;

   always_ff @(posedge clock) begin
      if (stg_load[4]) begin
         r4_ff   <= (yw3_ff >= yl3_ff) ? right3_ff : up3_ff;
         dir4_ff <= dir3_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: round half up to 16 fraction bits
   // ---------------------------------------------------------------------
   logic [SUM_W-1:0] t5_ff;
   direct_res_type dir5_ff;

   always_ff @(posedge clock) begin
      if (stg_load[5]) begin
         t5_ff   <= r4_ff + ROUND_HALF;
         dir5_ff <= dir4_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: saturate and output register
   // ---------------------------------------------------------------------
   logic                     t_neg, sat_pos, sat_neg;
   logic [PROJ_W-1:0]        val_in;
   logic                     inf_in, sat_in;
   logic [PROJ_W-1:0]        val6_ff;
   logic                     inf6_ff, sat6_ff;

   assign t_neg   = t5_ff[SUM_W-1];
   assign sat_pos = !t_neg && (|t5_ff[SUM_W-2:SAT_LSB]);
   assign sat_neg = t_neg && !(&t5_ff[SUM_W-2:SAT_LSB]);

   always_comb begin
      if (dir5_ff.direct) begin
         val_in = dir5_ff.value;
         inf_in = dir5_ff.inf;
         sat_in = 1'b0;
      end else if (sat_pos) begin
         val_in = PROJ_MAX;
         inf_in = 1'b0;
         sat_in = 1'b1;
      end else if (sat_neg) begin
         val_in = PROJ_MIN;
         inf_in = 1'b0;
         sat_in = 1'b1;
      end else begin
         val_in = t5_ff[RND_SHIFT +: PROJ_W];
         inf_in = 1'b0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_load[6]) begin
         val6_ff <= val_in;
         inf6_ff <= inf_in;
         sat6_ff <= sat_in;
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_STAGES-1];
   assign rsp_tdata  = val6_ff;
   assign rsp_tuser  = {sat6_ff, inf6_ff};

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_accept_fills_stage0: assert property (@(posedge clock) disable iff (reset)
      accept |=> vld_ff[0])
      else $error("accepted item missing from table read stage");

   a_inf_sat_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("result flagged both unprojected and saturated");

   a_inf_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("unprojected result carries a nonzero value");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata == PROJ_MAX || rsp_tdata == PROJ_MIN))
      else $error("saturated result is not a range limit");

endmodule
